>>> src/ffha_pkg.sv
// Package with the heap geometry, header type and request codes of the allocator.
package ffha_pkg;

   // Heap geometry.
   localparam int HEAP_BYTES   = 4096;
   localparam int HEADER_BYTES = 8;
   localparam int SLACK_RESET  = 10;

   // Offset and sum widths follow from the heap size; the request size width is fixed.
   localparam int OFF_W = $clog2(HEAP_BYTES);
   localparam int SUM_W = OFF_W + 2;
   localparam int REQ_W = 12;
   localparam int CMP_W = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 2;

   // Request kinds.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FIT  = 2'd1;
   localparam logic [1:0] ST_BAD_FREE = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HEAP_BASE   = 2'd0;
   localparam logic [1:0] CSR_SPLIT_SLACK = 2'd1;

   // One block header entry of the header memory.
   typedef struct packed {
      logic             start;
      logic             used;
      logic [OFF_W-1:0] size;
   } hdr_type;

endpackage

>>> src/first_fit_heap_allocator.sv
// First-fit heap allocator that walks block headers kept in one synchronous memory.
// An allocate reads headers from offset zero onward until a free block fits; a free checks the
// freed header, then walks all headers from offset zero and merges adjacent free blocks.
// One request is worked at a time; the walk over the header memory read port sets the rate.
// Reset is synchronous; afterwards a clearing pass rewrites every entry of the header
// memory, during which no request is accepted (configuration writes are taken).
module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [11:0] req_alloc_size,
   input  logic [31:0] req_block_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_payload_address,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ffha_pkg::*;

   // State codes.
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ACHK  = 4'd2;
   localparam logic [3:0] S_SPLIT = 4'd3;
   localparam logic [3:0] S_FCHK  = 4'd4;
   localparam logic [3:0] S_CRD0  = 4'd5;
   localparam logic [3:0] S_CCUR  = 4'd6;
   localparam logic [3:0] S_CNXT  = 4'd7;
   localparam logic [3:0] S_CKILL = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   localparam logic [SUM_W-1:0] HDR_S  = SUM_W'(HEADER_BYTES);
   localparam logic [SUM_W-1:0] HEAP_S = SUM_W'(HEAP_BYTES);

   // Header memory.
   hdr_type mem [HEAP_BYTES];
   hdr_type rd_data_ff;
   logic [OFF_W-1:0] rd_addr;
   logic             rd_en;
   logic [OFF_W-1:0] wr_addr;
   logic             wr_en;
   hdr_type          wr_data;

   // Control and working registers.
   logic [3:0]       state_ff, state_in;
   logic [OFF_W-1:0] clr_ff, clr_in;
   logic [31:0]      base_ff;
   logic [7:0]       slack_ff;
   logic [REQ_W-1:0] size_req_ff, size_req_in;
   logic [OFF_W-1:0] cur_ff, cur_in;
   logic [OFF_W-1:0] nxt_ff, nxt_in;
   logic [OFF_W-1:0] cur_size_ff, cur_size_in;
   logic             cur_used_ff, cur_used_in;
   logic [OFF_W-1:0] split_size_ff, split_size_in;
   logic [31:0]      res_addr_ff, res_addr_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic             rsp_valid_ff;
   logic [31:0]      rsp_addr_ff;
   logic [1:0]       rsp_status_ff;

   logic             req_take;
   logic [31:0]      free_off;
   logic [SUM_W-1:0] walk_nxt;
   logic [SUM_W-1:0] cur_walk_nxt;
   logic [SUM_W-1:0] merged;
   logic [CMP_W-1:0] split_need;
   logic             rsp_free;

   assign req_stall           = (state_ff != S_IDLE);
   assign req_take            = req_valid && !req_stall;
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_free            = !rsp_valid_ff || !rsp_stall;

   // Address arithmetic on the request and on the headers read.
   assign free_off     = req_block_address - base_ff - 32'(HEADER_BYTES);
   assign walk_nxt     = SUM_W'(nxt_ff) + HDR_S + SUM_W'(rd_data_ff.size);
   assign cur_walk_nxt = SUM_W'(cur_ff) + HDR_S + SUM_W'(cur_size_ff);
   assign merged       = SUM_W'(cur_size_ff) + HDR_S + SUM_W'(rd_data_ff.size);
   assign split_need   = CMP_W'(size_req_ff) + CMP_W'(HEADER_BYTES) + CMP_W'(slack_ff);

   // Next-state and memory access logic.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      size_req_in   = size_req_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      cur_size_in   = cur_size_ff;
      cur_used_in   = cur_used_ff;
      split_size_in = split_size_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rd_en         = 1'b0;
      rd_addr       = nxt_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == '0) begin
               wr_data.start = 1'b1;
               wr_data.size  = OFF_W'(HEAP_BYTES - HEADER_BYTES);
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == OFF_W'(HEAP_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               size_req_in   = req_alloc_size;
               res_addr_in   = '0;
               if (req_kind == KIND_ALLOC) begin
                  nxt_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_ACHK;
               end else if (free_off >= 32'(HEAP_BYTES)) begin
                  res_status_in = ST_BAD_FREE;
                  state_in      = S_FIN;
               end else begin
                  nxt_in   = free_off[OFF_W-1:0];
                  rd_en    = 1'b1;
                  rd_addr  = free_off[OFF_W-1:0];
                  state_in = S_FCHK;
               end
            end
         end
         S_ACHK: begin
            // Data of the block at nxt_ff is in rd_data_ff.
            if (!rd_data_ff.start) begin
               res_status_in = ST_NO_FIT;
               state_in      = S_FIN;
            end else if (!rd_data_ff.used &&
                         CMP_W'(rd_data_ff.size) >= CMP_W'(size_req_ff)) begin
               wr_en         = 1'b1;
               wr_addr       = nxt_ff;
               wr_data.start = 1'b1;
               wr_data.used  = 1'b1;
               res_addr_in   = base_ff + 32'(nxt_ff) + 32'(HEADER_BYTES);
               res_status_in = ST_OK;
               if (CMP_W'(rd_data_ff.size) >= split_need) begin
                  wr_data.size  = OFF_W'(size_req_ff);
                  split_size_in = OFF_W'(CMP_W'(rd_data_ff.size) - CMP_W'(size_req_ff)
                                         - CMP_W'(HEADER_BYTES));
                  cur_in        = OFF_W'(SUM_W'(nxt_ff) + HDR_S + SUM_W'(size_req_ff));
                  state_in      = S_SPLIT;
               end else begin
                  wr_data.size = rd_data_ff.size;
                  state_in     = S_FIN;
               end
            end else if (walk_nxt >= HEAP_S) begin
               res_status_in = ST_NO_FIT;
               state_in      = S_FIN;
            end else begin
               nxt_in  = walk_nxt[OFF_W-1:0];
               rd_en   = 1'b1;
               rd_addr = walk_nxt[OFF_W-1:0];
            end
         end
         S_SPLIT: begin
            // Write the free remainder after the newly used block.
            wr_en         = 1'b1;
            wr_addr       = cur_ff;
            wr_data.start = 1'b1;
            wr_data.size  = split_size_ff;
            state_in      = S_FIN;
         end
         S_FCHK: begin
            res_status_in = ST_OK;
            if (!rd_data_ff.start || !rd_data_ff.used) begin
               res_status_in = ST_BAD_FREE;
               state_in      = S_FIN;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = nxt_ff;
               wr_data.start = 1'b1;
               wr_data.size  = rd_data_ff.size;
               state_in      = S_CRD0;
            end
         end
         S_CRD0: begin
            // Start the merge walk at offset zero.
            cur_in   = '0;
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_CCUR;
         end
         S_CCUR: begin
            if (!rd_data_ff.start) begin
               state_in = S_FIN;
            end else begin
               cur_size_in = rd_data_ff.size;
               cur_used_in = rd_data_ff.used;
               if (SUM_W'(cur_ff) + HDR_S + SUM_W'(rd_data_ff.size) >= HEAP_S) begin
                  state_in = S_FIN;
               end else begin
                  nxt_in   = OFF_W'(SUM_W'(cur_ff) + HDR_S + SUM_W'(rd_data_ff.size));
                  rd_en    = 1'b1;
                  rd_addr  = OFF_W'(SUM_W'(cur_ff) + HDR_S + SUM_W'(rd_data_ff.size));
                  state_in = S_CNXT;
               end
            end
         end
         S_CNXT: begin
            // rd_data_ff holds the block after cur_ff.
            if (!rd_data_ff.start) begin
               state_in = S_FIN;
            end else if (!cur_used_ff && !rd_data_ff.used) begin
               wr_en        = 1'b1;
               wr_addr      = cur_ff;
               wr_data.start = 1'b1;
               wr_data.size = merged[OFF_W-1:0];
               cur_size_in  = merged[OFF_W-1:0];
               state_in     = S_CKILL;
            end else begin
               cur_in      = nxt_ff;
               cur_size_in = rd_data_ff.size;
               cur_used_in = rd_data_ff.used;
               if (walk_nxt >= HEAP_S) begin
                  state_in = S_FIN;
               end else begin
                  nxt_in  = walk_nxt[OFF_W-1:0];
                  rd_en   = 1'b1;
                  rd_addr = walk_nxt[OFF_W-1:0];
               end
            end
         end
         S_CKILL: begin
            // Erase the absorbed header, then look at the block after the merged one.
            wr_en   = 1'b1;
            wr_addr = nxt_ff;
            if (cur_walk_nxt >= HEAP_S) begin
               state_in = S_FIN;
            end else begin
               nxt_in   = cur_walk_nxt[OFF_W-1:0];
               rd_en    = 1'b1;
               rd_addr  = cur_walk_nxt[OFF_W-1:0];
               state_in = S_CNXT;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Header memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         slack_ff     <= 8'(SLACK_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEAP_BASE) begin
               base_ff <= csr_data;
            end else if (csr_index == CSR_SPLIT_SLACK) begin
               slack_ff <= csr_data[7:0];
            end
         end
         if (state_ff == S_FIN && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      size_req_ff   <= size_req_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      cur_size_ff   <= cur_size_in;
      cur_used_ff   <= cur_used_in;
      split_size_ff <= split_size_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      if (state_ff == S_FIN && rsp_free) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

endmodule
